// ===== src/pru_pkg.sv =====
// Shared types, codes and constants of the pixel replicating upscaler.
`timescale 1ns / 1ps

package pru_pkg;

	// Default line store depth in pixels
	localparam int MAX_ROW_PIXELS_DEF = 1024;

	// Largest replication factor honored
	localparam logic [6:0] FACTOR_LIMIT = 7'd100;

	// Configuration port widths and register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int SCALE_W     = 7;
	localparam int ROW_WIDTH_W = 11;

	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH    = 2'd1;

	// Input word kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_PIXEL = 2'd0,
		STATUS_PAD   = 2'd1,
		STATUS_DROP  = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_word_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       row_end;
		logic       block_end;
	} out_word_t;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} fifo_push_t;

	typedef struct packed {
		logic      not_empty;
		out_word_t word;
	} fifo_rd_t;

endpackage

// ===== src/pru_front.sv =====
// Front end: configuration, line store, replay counters and result classification.
`timescale 1ns / 1ps

module pru_front #(
	parameter int MAX_ROW_PIXELS = pru_pkg::MAX_ROW_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  pru_pkg::in_word_t                   item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pru_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  pru_pkg::fifo_cnt_t                  fifo_count,
	output pru_pkg::fifo_push_t                 push
);

	localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
	localparam int CW = ($clog2(MAX_ROW_PIXELS + 1) > pru_pkg::ROW_WIDTH_W) ?
		$clog2(MAX_ROW_PIXELS + 1) : pru_pkg::ROW_WIDTH_W;
	localparam logic [CW-1:0] MAX_W = CW'(MAX_ROW_PIXELS);

	// Configuration registers
	logic [pru_pkg::SCALE_W-1:0]     scale_q;
	logic [pru_pkg::ROW_WIDTH_W-1:0] row_width_q;

	// Replay and load state
	logic [CW-1:0]               load_col_q;
	logic                        replay_q;
	logic [CW-1:0]               read_col_q;
	logic [pru_pkg::SCALE_W-1:0] copy_q;
	logic [pru_pkg::SCALE_W-1:0] rep_q;
	logic [1:0]                  padc_q;

	// Line store
	logic [23:0] line_mem [MAX_ROW_PIXELS];
	logic [23:0] px_s1;

	// Stage one
	logic               valid_s1;
	pru_pkg::status_t   status_s1;
	logic               row_end_s1;
	logic               block_end_s1;

	logic                        accept;
	logic                        is_pixel;
	logic [CW-1:0]               eff_w;
	logic [pru_pkg::SCALE_W-1:0] eff_s;
	logic [3:0]                  pad_prod;
	logic [1:0]                  pad_len;
	logic [CW:0]                 load_inc;
	logic [CW:0]                 read_inc;
	logic [pru_pkg::SCALE_W:0]   copy_inc;
	logic [pru_pkg::SCALE_W:0]   rep_inc;
	logic [2:0]                  pad_inc;
	logic                        in_pixels;
	logic                        copy_done;
	logic                        pad_done;
	logic                        row_done;
	logic                        blk_done;
	logic                        store_we;
	logic                        store_re;

	assign cfg_ready = 1'b1;

	// Take configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= pru_pkg::SCALE_W'(1);
			row_width_q <= pru_pkg::ROW_WIDTH_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pru_pkg::CFG_SCALE_FACTOR: scale_q <= cfg_data[pru_pkg::SCALE_W-1:0];
				pru_pkg::CFG_ROW_WIDTH:    row_width_q <= cfg_data[pru_pkg::ROW_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp width and factor to their legal ranges
	always_comb begin
		if (row_width_q == '0)
			eff_w = CW'(1);
		else if (CW'(row_width_q) > MAX_W)
			eff_w = MAX_W;
		else
			eff_w = CW'(row_width_q);
		eff_s = (scale_q > pru_pkg::FACTOR_LIMIT) ? pru_pkg::FACTOR_LIMIT : scale_q;
	end

	// Pad bytes per output row: (width * factor) mod 4
	assign pad_prod = {2'b00, eff_w[1:0]} * {2'b00, eff_s[1:0]};
	assign pad_len  = pad_prod[1:0];

	// Keep room in the queue for the word in stage one
	assign item_ready = (fifo_count + pru_pkg::FIFO_CNT_W'(valid_s1)) <
		pru_pkg::FIFO_CNT_W'(pru_pkg::FIFO_DEPTH);
	assign accept     = item_valid && item_ready;
	assign is_pixel   = (item.kind == pru_pkg::KIND_PIXEL);

	// Counter steps and phase ends
	assign load_inc  = {1'b0, load_col_q} + 1'b1;
	assign read_inc  = {1'b0, read_col_q} + 1'b1;
	assign copy_inc  = {1'b0, copy_q} + 1'b1;
	assign rep_inc   = {1'b0, rep_q} + 1'b1;
	assign pad_inc   = {1'b0, padc_q} + 1'b1;
	assign in_pixels = (read_col_q < eff_w);
	assign copy_done = (copy_inc >= {1'b0, eff_s});
	assign pad_done  = (pad_inc >= {1'b0, pad_len});
	assign row_done  = in_pixels ?
		(copy_done && (read_inc >= {1'b0, eff_w}) && (pad_len == 2'd0)) : pad_done;
	assign blk_done  = row_done && (rep_inc >= {1'b0, eff_s});

	// Advance load and replay counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q <= '0;
			replay_q   <= 1'b0;
			read_col_q <= '0;
			copy_q     <= '0;
			rep_q      <= '0;
			padc_q     <= '0;
		end else if (accept) begin
			if (is_pixel) begin
				if (!replay_q) begin
					if (load_inc >= {1'b0, eff_w}) begin
						load_col_q <= '0;
						if (eff_s != '0) begin
							replay_q   <= 1'b1;
							read_col_q <= '0;
							copy_q     <= '0;
							rep_q      <= '0;
							padc_q     <= '0;
						end
					end else begin
						load_col_q <= load_inc[CW-1:0];
					end
				end
			end else if (replay_q) begin
				if (row_done) begin
					read_col_q <= '0;
					copy_q     <= '0;
					padc_q     <= '0;
					if (blk_done) begin
						replay_q <= 1'b0;
						rep_q    <= '0;
					end else begin
						rep_q <= rep_inc[pru_pkg::SCALE_W-1:0];
					end
				end else if (in_pixels) begin
					if (copy_done) begin
						copy_q     <= '0;
						read_col_q <= read_inc[CW-1:0];
					end else begin
						copy_q <= copy_inc[pru_pkg::SCALE_W-1:0];
					end
				end else begin
					padc_q <= pad_inc[1:0];
				end
			end
		end
	end

	// Write loaded pixels, read stored pixels during replay
	assign store_we = accept && is_pixel && !replay_q && (load_col_q < MAX_W);
	assign store_re = accept && !is_pixel && replay_q && in_pixels;

	always_ff @(posedge clk) begin
		if (store_we)
			line_mem[load_col_q[AW-1:0]] <= {item.red, item.green, item.blue};
		if (store_re)
			px_s1 <= line_mem[read_col_q[AW-1:0]];
	end

	// Classify the word: every word taken during replay yields a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept && replay_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_pixel) begin
				status_s1    <= pru_pkg::STATUS_DROP;
				row_end_s1   <= 1'b0;
				block_end_s1 <= 1'b0;
			end else begin
				status_s1    <= in_pixels ? pru_pkg::STATUS_PIXEL : pru_pkg::STATUS_PAD;
				row_end_s1   <= row_done;
				block_end_s1 <= blk_done;
			end
		end
	end

	// Hand the finished word to the queue
	always_comb begin
		push.valid          = valid_s1;
		push.word.status    = status_s1;
		push.word.row_end   = row_end_s1;
		push.word.block_end = block_end_s1;
		if (status_s1 == pru_pkg::STATUS_PIXEL) begin
			push.word.out_blue  = px_s1[7:0];
			push.word.out_green = px_s1[15:8];
			push.word.out_red   = px_s1[23:16];
		end else begin
			push.word.out_blue  = 8'h00;
			push.word.out_green = 8'h00;
			push.word.out_red   = 8'h00;
		end
	end

endmodule

// ===== src/pru_fifo.sv =====
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps

module pru_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  pru_pkg::fifo_push_t push,
	input  logic                pop,
	output pru_pkg::fifo_rd_t   rd,
	output pru_pkg::fifo_cnt_t  count
);

	pru_pkg::out_word_t             slot_q [pru_pkg::FIFO_DEPTH];
	logic [pru_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [pru_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	pru_pkg::fifo_cnt_t             count_q;

	assign count        = count_q;
	assign rd.not_empty = (count_q != '0);
	assign rd.word      = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push.valid)
			slot_q[wr_ptr_q] <= push.word;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push.valid && !pop)
				count_q <= count_q + 1'b1;
			else if (!push.valid && pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== src/pru_out.sv =====
// Output stage: holds one result word for the receiver.
`timescale 1ns / 1ps

module pru_out (
	input  logic               clk,
	input  logic               arst_n,
	input  pru_pkg::fifo_rd_t  rd,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output pru_pkg::out_word_t result
);

	logic               valid_q;
	pru_pkg::out_word_t word_q;

	// Refill when empty or when the held word leaves
	assign pop          = rd.not_empty && (!valid_q || result_ready);
	assign result_valid = valid_q;
	assign result       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (result_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			word_q <= rd.word;
	end

endmodule

// ===== src/pixel_replicating_upscaler.sv =====
// Top level of the pixel replicating upscaler.
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
// Channels: item (valid/ready) carries either a source pixel to load or a
// tick; result (valid/ready) carries output pixels, pad bytes and drop
// flags; cfg (valid/ready, always ready) writes scale_factor (index 0) and
// row_width (index 1); only write them while the block is idle (unenforced).
// A complete source row starts replay when the factor is not zero; each
// tick then yields one result: every pixel repeated by the factor, zero pad
// bytes up to a multiple of four bytes, the whole row repeated by the
// factor. A pixel arriving during replay yields a drop word.
// A word on its way to result_valid is registered in stage one (with the
// line store read), then in the queue, then in the output register.
// Throughput: one word per cycle while item_ready is high, set by the single
// line store port used per word and the counter update in the front end.
// Reset clears all counters and queues and sets both registers to 1; the
// line store holds nothing valid until a row is loaded.
// When the receiver stalls, up to five results collect in the output
// register, the queue and stage one before item_ready drops.

module pixel_replicating_upscaler #(
	parameter int MAX_ROW_PIXELS = pru_pkg::MAX_ROW_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  pru_pkg::in_word_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output pru_pkg::out_word_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pru_pkg::fifo_push_t push;
	pru_pkg::fifo_rd_t   fifo_rd;
	pru_pkg::fifo_cnt_t  fifo_count;
	logic                pop;

	pru_front #(
		.MAX_ROW_PIXELS(MAX_ROW_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fifo_count (fifo_count),
		.push       (push)
	);

	pru_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.rd     (fifo_rd),
		.count  (fifo_count)
	);

	pru_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (fifo_rd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== src/pru_checker.sv =====
// Port-level checks of the pixel replicating upscaler, bound to the top level.
`timescale 1ns / 1ps

module pru_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input pru_pkg::out_word_t result
);

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// A drop word never closes a row
	a_drop_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == pru_pkg::STATUS_DROP) |->
		!result.row_end && !result.block_end)
		else $error("drop word marked as row end");

	// The end of a block is also the end of a row
	a_block_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.block_end |-> result.row_end)
		else $error("block end without row end");

	// Only pixel words carry color
	a_zero_color: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != pru_pkg::STATUS_PIXEL) |->
		(result.out_blue == 8'h00) && (result.out_green == 8'h00) &&
		(result.out_red == 8'h00))
		else $error("non-pixel word with color bytes");

endmodule

bind pixel_replicating_upscaler pru_checker u_pru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the pixel replicating upscaler.
`timescale 1ns / 1ps

module testbench;
	import pru_pkg::*;

	localparam int          LINE_PIXELS = MAX_ROW_PIXELS_DEF;
	localparam int          LINE_AW     = $clog2(LINE_PIXELS);
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int          DRAIN_WAIT  = 8;
	localparam int          RANDOM_WORDS = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      item_valid = 1'b0;
	logic      item_ready;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_word_t result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Stimulus and scoreboard
	in_word_t    pending_items[$];
	out_word_t   expected_words[$];
	out_word_t   want;
	int unsigned items_pushed = 0;
	int unsigned items_taken = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic        item_fire = 1'b0;

	// Upscaler state as seen by the predictor
	logic [23:0]     line_mem [LINE_PIXELS];
	logic [SCALE_W-1:0]     factor_reg = 7'd1;
	logic [ROW_WIDTH_W-1:0] row_width_reg = 11'd1;
	int unsigned load_col = 0;
	int unsigned rd_col = 0;
	int unsigned copy_cnt = 0;
	int unsigned repeat_cnt = 0;
	int unsigned pad_cnt = 0;
	bit          replaying = 1'b0;

	pixel_replicating_upscaler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Predict the result of one accepted word and advance the state
	task automatic upscale_step(input in_word_t w_in);
		int unsigned wd;
		int unsigned fc;
		int unsigned pad;
		bit          row_done;
		bit          blk_done;
		out_word_t   res;
		wd = (row_width_reg == '0) ? 1 :
			(32'(row_width_reg) > LINE_PIXELS) ? LINE_PIXELS : 32'(row_width_reg);
		fc = (factor_reg > FACTOR_LIMIT) ? 32'(FACTOR_LIMIT) : 32'(factor_reg);
		row_done = 1'b0;
		blk_done = 1'b0;
		res = '0;
		if (w_in.kind == KIND_PIXEL) begin
			if (replaying) begin
				// drop the pixel and flag it
				res.status = STATUS_DROP;
				expected_words.push_back(res);
			end else begin
				if (load_col < LINE_PIXELS) begin
					line_mem[load_col[LINE_AW-1:0]] = {w_in.red, w_in.green, w_in.blue};
				end
				load_col++;
				if (load_col >= wd) begin
					load_col = 0;
					if (fc != 0) begin
						replaying = 1'b1;
						rd_col = 0;
						copy_cnt = 0;
						repeat_cnt = 0;
						pad_cnt = 0;
					end
				end
			end
		end else if (replaying) begin
			pad = (wd * fc) & 3;
			if (rd_col < wd) begin
				res.status = STATUS_PIXEL;
				{res.out_red, res.out_green, res.out_blue} = line_mem[rd_col[LINE_AW-1:0]];
				copy_cnt++;
				if (copy_cnt >= fc) begin
					copy_cnt = 0;
					rd_col++;
					if (rd_col >= wd && pad == 0) begin
						row_done = 1'b1;
					end
				end
			end else begin
				res.status = STATUS_PAD;
				pad_cnt++;
				if (pad_cnt >= pad) begin
					row_done = 1'b1;
				end
			end
			// close the output row, and the block after the last repeat
			if (row_done) begin
				rd_col = 0;
				copy_cnt = 0;
				pad_cnt = 0;
				repeat_cnt++;
				if (repeat_cnt >= fc) begin
					blk_done = 1'b1;
					replaying = 1'b0;
					repeat_cnt = 0;
				end
			end
			res.row_end = row_done;
			res.block_end = blk_done;
			expected_words.push_back(res);
		end
	endtask

	task automatic push_pixel(input logic [23:0] rgb);
		in_word_t w;
		w.kind = KIND_PIXEL;
		{w.red, w.green, w.blue} = rgb;
		pending_items.push_back(w);
		items_pushed++;
	endtask

	task automatic push_tick();
		in_word_t w;
		w.kind = KIND_TICK;
		{w.red, w.green, w.blue} = 24'($urandom);
		pending_items.push_back(w);
		items_pushed++;
	endtask

	// Wait until every word is taken and every result has come back
	task automatic settle();
		while (items_taken != items_pushed || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Tick until the current replay is over; surplus ticks are ignored
	task automatic finish_replay();
		settle();
		while (replaying) begin
			repeat (8) push_tick();
			settle();
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SCALE_FACTOR) begin
			factor_reg = val[SCALE_W-1:0];
		end else begin
			row_width_reg = val[ROW_WIDTH_W-1:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 46;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 46;
			end
			default: begin
				send_idle_pct = 21;
				stall_pct = 21;
			end
		endcase
	endtask

	// Drive the next word and the result ready at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_fire) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check results against the oldest expectation, then predict taken words
	always @(posedge clk) begin
		item_fire <= arst_n && item_valid && item_ready;
		if (arst_n && result_valid && result_ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: %h", result);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (result.out_blue !== want.out_blue) begin
					$error("out_blue: expected %h, got %h", want.out_blue, result.out_blue);
					errors++;
				end
				if (result.out_green !== want.out_green) begin
					$error("out_green: expected %h, got %h", want.out_green, result.out_green);
					errors++;
				end
				if (result.out_red !== want.out_red) begin
					$error("out_red: expected %h, got %h", want.out_red, result.out_red);
					errors++;
				end
				if (result.row_end !== want.row_end) begin
					$error("row_end: expected %b, got %b", want.row_end, result.row_end);
					errors++;
				end
				if (result.block_end !== want.block_end) begin
					$error("block_end: expected %b, got %b", want.block_end, result.block_end);
					errors++;
				end
			end
		end
		if (arst_n && item_valid && item_ready) begin
			upscale_step(item);
			items_taken++;
		end
	end

	// End a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned wd;
		int unsigned fc;
		int unsigned n_ticks;
		int unsigned counted;
		int unsigned seq;
		int unsigned k;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: two rows, a dropped pixel, a stray tick
		set_idling(0);
		push_pixel(24'hFF_FFFF);
		push_pixel(24'h5A_A55A);
		push_tick();
		push_tick();
		push_tick();
		push_pixel(24'h00_0000);
		push_tick();
		push_tick();
		settle();

		// Width zero and factor zero: the row is discarded
		write_reg(CFG_ROW_WIDTH, 0);
		write_reg(CFG_SCALE_FACTOR, 0);
		push_pixel(24'($urandom));
		push_tick();
		settle();

		// Pad phase entered before the factor change makes the pad length zero
		write_reg(CFG_ROW_WIDTH, 1);
		write_reg(CFG_SCALE_FACTOR, 2);
		push_pixel(24'($urandom));
		repeat (3) push_tick();
		settle();
		write_reg(CFG_SCALE_FACTOR, 4);
		finish_replay();

		// Shrink the width in the middle of an output row
		write_reg(CFG_ROW_WIDTH, 3);
		write_reg(CFG_SCALE_FACTOR, 1);
		repeat (3) push_pixel(24'($urandom));
		repeat (2) push_tick();
		settle();
		write_reg(CFG_ROW_WIDTH, 1);
		finish_replay();

		// Factor above the limit, cut short by lowering it mid-row
		write_reg(CFG_SCALE_FACTOR, 127);
		push_pixel(24'($urandom));
		repeat (120) push_tick();
		settle();
		write_reg(CFG_SCALE_FACTOR, 1);
		finish_replay();

		// Width above the store depth, then narrowed to close the row
		write_reg(CFG_ROW_WIDTH, 2047);
		repeat (3) push_pixel(24'($urandom));
		settle();
		write_reg(CFG_ROW_WIDTH, 2);
		push_pixel(24'($urandom));
		finish_replay();

		// Random rows, mostly well formed, some cut short
		counted = 0;
		seq = 0;
		while (counted < RANDOM_WORDS) begin
			set_idling((seq / 3) % 4);
			if (seq == 0 || $urandom_range(3) != 0) begin
				if ($urandom_range(9) == 0) begin
					wd = $urandom_range(11, 48);
				end else begin
					wd = $urandom_range(1, 10);
				end
				write_reg(CFG_ROW_WIDTH, wd);
			end
			if (seq == 0 || $urandom_range(3) != 0) begin
				fc = $urandom_range(0, 5);
				write_reg(CFG_SCALE_FACTOR, fc);
			end
			wd = 32'(row_width_reg);
			fc = 32'(factor_reg);
			if (wd > 1 && $urandom_range(7) == 0) begin
				// partial row, finished under the next settings
				k = $urandom_range(1, wd - 1);
				repeat (k) push_pixel(24'($urandom));
				counted += k;
			end else begin
				for (k = 0; k < wd; k++) begin
					if ($urandom_range(9) == 0) begin
						push_tick();
					end
					push_pixel(24'($urandom));
					counted++;
				end
				n_ticks = fc * (wd * fc + ((wd * fc) & 3));
				for (k = 0; k < n_ticks; k++) begin
					if ($urandom_range(11) == 0) begin
						push_pixel(24'($urandom));
						counted++;
					end
					push_tick();
					counted++;
				end
			end
			finish_replay();
			seq++;
		end

		settle();
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== pixel_replicating_upscaler.f =====
src/pru_pkg.sv
src/pru_front.sv
src/pru_fifo.sv
src/pru_out.sv
src/pixel_replicating_upscaler.sv
src/pru_checker.sv
dv/testbench.sv
